// ----- rtl/assert_macros.svh -----
// Assertion helpers. The enclosing module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Whenever the trigger is high, the consequence must hold in the same cycle.
`define ASSERT_IMPLIES(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/hbpd_pkg.sv -----
package hbpd_pkg;

  localparam int unsigned PACKET_BYTES = 16;
  localparam int unsigned BYTE_CNT_W   = 5;
  localparam int unsigned DEN_W        = 20;

  localparam int unsigned FLY_RPM_NUM   = 576000;
  localparam int unsigned CRANK_RPM_NUM = 500000;
  localparam logic [15:0] SPEED_LIMIT   = 16'd65534;

  localparam logic [3:0] HDR_NIB_HI = 4'h6;
  localparam logic [3:0] HDR_NIB_LO = 4'hA;

  localparam logic [2:0] ST_SKIP       = 3'd0;
  localparam logic [2:0] ST_INCOMPLETE = 3'd1;
  localparam logic [2:0] ST_INVALID    = 3'd2;
  localparam logic [2:0] ST_COMPLETE   = 3'd3;
  localparam logic [2:0] ST_REVERSED   = 3'd4;

  localparam logic [1:0] JOB_FLY_RPM   = 2'd0;
  localparam logic [1:0] JOB_CRANK_RPM = 2'd1;
  localparam logic [1:0] JOB_WHEEL     = 2'd2;
  localparam logic [1:0] JOB_CRANK     = 2'd3;

  typedef struct packed {
    logic       capture;
    logic       step;
    logic       div_start;
    logic       div_store;
    logic [1:0] job;
    logic       load_out;
  } hbpd_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } hbpd_stat_t;

endpackage

// ----- rtl/hbpd_div.sv -----
`include "assert_macros.svh"

module hbpd_div
  import hbpd_pkg::*;
#(
  parameter int unsigned NW = 54,
  parameter int unsigned DW = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0]    sh_r, sh_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    den_r, den_nxt;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             ge;

  // Restoring division: one quotient bit per cycle, quotient shifts in from the bottom.
  assign trial = {rem_r, sh_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NW);
      sh_nxt   = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      sh_nxt  = {sh_r[NW-2:0], ge};
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = sh_r;

  `ASSERT_IMPLIES(a_start_idle, start, !busy_r, "divider started while busy")

endmodule

// ----- rtl/hbpd_ctrl.sv -----
`include "assert_macros.svh"

module hbpd_ctrl
  import hbpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  hbpd_stat_t stat,
  output hbpd_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_STEP     = 3'd1;
  localparam logic [2:0] S_DIV_GO   = 3'd2;
  localparam logic [2:0] S_DIV_WAIT = 3'd3;
  localparam logic [2:0] S_EMIT     = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [1:0] job_r, job_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.job       = job_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        job_nxt   = JOB_FLY_RPM;
        state_nxt = stat.need_div ? S_DIV_GO : S_EMIT;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.div_store = 1'b1;
          if (job_r == JOB_CRANK) begin
            state_nxt = S_EMIT;
          end else begin
            job_nxt   = job_r + 2'd1;
            state_nxt = S_DIV_GO;
          end
        end
      end
      S_EMIT: begin
        // The output register is free when it is empty or its transaction completes this cycle.
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      job_r       <= JOB_FLY_RPM;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_IMPLIES(a_load_free, cmd.load_out, !out_valid_r || out_ready,
                  "result loaded over an untaken result")

endmodule

// ----- rtl/hbpd_datapath.sv -----
`include "assert_macros.svh"

module hbpd_datapath
  import hbpd_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  hbpd_cmd_t   cmd,
  output hbpd_stat_t  stat,
  input  logic [7:0]  in_input_char,
  input  logic [31:0] in_timestamp_ms,
  output logic [2:0]  out_status,
  output logic [7:0]  out_steering,
  output logic [7:0]  out_heart_rate,
  output logic [7:0]  out_brake_right,
  output logic [7:0]  out_brake_left,
  output logic [15:0] out_button_flags,
  output logic [15:0] out_crank_rpm,
  output logic [15:0] out_flywheel_rpm,
  output logic [15:0] out_crank_revolutions,
  output logic [31:0] out_wheel_revolutions,
  output logic [31:0] out_event_time
);

  localparam int unsigned TW = 32 + FRACTION_BITS;
  localparam int unsigned NW = 38 + FRACTION_BITS;
  localparam logic [TW-1:0] ROUND_HALF = TW'(1) << (FRACTION_BITS - 1);

  logic [7:0]            ch_r;
  logic [31:0]           ts_r;
  logic [7:0]            bytes_r [PACKET_BYTES];
  logic [3:0]            nib_r, nib_nxt;
  logic                  nib_valid_r, nib_valid_nxt;
  logic [BYTE_CNT_W-1:0] count_r, count_nxt;
  logic [7:0]            chk_r, chk_nxt;
  logic [31:0]           last_time_r, last_time_nxt;
  logic [31:0]           dt_r, dt_nxt;
  logic [2:0]            status_r, status_nxt;
  logic [TW-1:0]         wheel_total_r, wheel_total_nxt;
  logic [TW-1:0]         crank_total_r, crank_total_nxt;
  logic [15:0]           fly_rpm_r, crank_rpm_r;

  logic        is_dig, is_hex;
  logic [7:0]  ch_off;
  logic [3:0]  nib_in, hdr_expect;
  logic [7:0]  new_byte;
  logic        byte_wr;
  logic [31:0] lt;

  logic [15:0]    fly, crank, fdiv;
  logic           fly_on, crank_on;
  logic [37:0]    dt48, dt25;
  logic [NW-1:0]  div_num, div_quo;
  logic [DEN_W-1:0] div_den;
  logic           div_done;
  logic [15:0]    quo_sat;
  logic [TW-1:0]  crank_round, wheel_round;

  // Character decode and packet assembly for one item.
  assign is_dig     = (ch_r >= 8'h30) && (ch_r <= 8'h39);
  assign is_hex     = (ch_r >= 8'h61) && (ch_r <= 8'h66);
  assign ch_off     = is_dig ? (ch_r - 8'h30) : (ch_r - 8'h57);
  assign nib_in     = ch_off[3:0];
  assign hdr_expect = nib_valid_r ? HDR_NIB_LO : HDR_NIB_HI;
  assign new_byte   = {nib_r, nib_in};
  assign lt         = (last_time_r != 32'd0) ? last_time_r : ts_r;

  always_comb begin
    nib_nxt         = nib_r;
    nib_valid_nxt   = nib_valid_r;
    count_nxt       = count_r;
    chk_nxt         = chk_r;
    last_time_nxt   = last_time_r;
    dt_nxt          = dt_r;
    status_nxt      = ST_INCOMPLETE;
    byte_wr         = 1'b0;
    wheel_total_nxt = wheel_total_r;
    crank_total_nxt = crank_total_r;
    priority if (!(is_dig || is_hex)) begin
      nib_nxt       = '0;
      nib_valid_nxt = 1'b0;
      count_nxt     = '0;
      chk_nxt       = '0;
      status_nxt    = ST_INVALID;
    end else if ((count_r == '0) && (nib_in != hdr_expect)) begin
      nib_nxt       = '0;
      nib_valid_nxt = 1'b0;
      status_nxt    = ST_SKIP;
    end else if (!nib_valid_r) begin
      nib_nxt       = nib_in;
      nib_valid_nxt = 1'b1;
    end else begin
      nib_nxt       = '0;
      nib_valid_nxt = 1'b0;
      byte_wr       = 1'b1;
      count_nxt     = count_r + BYTE_CNT_W'(1);
      if (count_r != BYTE_CNT_W'(PACKET_BYTES - 1)) begin
        chk_nxt = chk_r ^ new_byte;
      end else begin
        // Last byte: chk_r holds the XOR of every byte before it.
        count_nxt = '0;
        chk_nxt   = '0;
        if (chk_r != new_byte) begin
          status_nxt = ST_INVALID;
        end else begin
          last_time_nxt = ts_r;
          if (ts_r < lt) begin
            wheel_total_nxt = '0;
            crank_total_nxt = '0;
            status_nxt      = ST_REVERSED;
          end else begin
            dt_nxt     = ts_r - lt;
            status_nxt = ST_COMPLETE;
          end
        end
      end
    end
  end

  assign stat.need_div = (status_nxt == ST_COMPLETE);
  assign stat.div_done = div_done;

  // Speed words and shared divider operands.
  assign fly      = {bytes_r[12], bytes_r[13]};
  assign crank    = {bytes_r[10], bytes_r[11]};
  assign fdiv     = (fly == 16'd0) ? 16'd1 : fly;
  assign fly_on   = (fly < SPEED_LIMIT);
  assign crank_on = (crank != 16'd0) && (crank < SPEED_LIMIT);
  assign dt48     = {1'b0, dt_r, 5'b0} + {2'b0, dt_r, 4'b0};
  assign dt25     = {2'b0, dt_r, 4'b0} + {3'b0, dt_r, 3'b0} + {6'b0, dt_r};

  always_comb begin
    unique case (cmd.job)
      JOB_FLY_RPM: begin
        div_num = NW'(FLY_RPM_NUM);
        div_den = DEN_W'(fdiv);
      end
      JOB_CRANK_RPM: begin
        div_num = NW'(CRANK_RPM_NUM);
        div_den = DEN_W'({crank, 1'b0}) + DEN_W'(crank);
      end
      JOB_WHEEL: begin
        div_num = {dt48, {FRACTION_BITS{1'b0}}};
        div_den = DEN_W'({fdiv, 2'b0}) + DEN_W'(fdiv);
      end
      default: begin
        div_num = {dt25, {FRACTION_BITS{1'b0}}};
        div_den = DEN_W'({crank, 3'b0}) + DEN_W'(crank);
      end
    endcase
  end

  hbpd_div #(
    .NW (NW),
    .DW (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign quo_sat = (|div_quo[NW-1:16]) ? 16'hFFFF : div_quo[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nib_r         <= '0;
      nib_valid_r   <= 1'b0;
      count_r       <= '0;
      chk_r         <= '0;
      last_time_r   <= '0;
      wheel_total_r <= '0;
      crank_total_r <= '0;
    end else if (cmd.step) begin
      nib_r         <= nib_nxt;
      nib_valid_r   <= nib_valid_nxt;
      count_r       <= count_nxt;
      chk_r         <= chk_nxt;
      last_time_r   <= last_time_nxt;
      wheel_total_r <= wheel_total_nxt;
      crank_total_r <= crank_total_nxt;
    end else if (cmd.div_store) begin
      if ((cmd.job == JOB_WHEEL) && fly_on) begin
        wheel_total_r <= wheel_total_r + div_quo[TW-1:0];
      end
      if ((cmd.job == JOB_CRANK) && crank_on) begin
        crank_total_r <= crank_total_r + div_quo[TW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch_r <= in_input_char;
      ts_r <= in_timestamp_ms;
    end
    if (cmd.step) begin
      status_r <= status_nxt;
      dt_r     <= dt_nxt;
      if (byte_wr) begin
        bytes_r[count_r[3:0]] <= new_byte;
      end
    end
    if (cmd.div_store && (cmd.job == JOB_FLY_RPM)) begin
      fly_rpm_r <= fly_on ? quo_sat : 16'd0;
    end
    if (cmd.div_store && (cmd.job == JOB_CRANK_RPM)) begin
      crank_rpm_r <= crank_on ? quo_sat : 16'd0;
    end
  end

  assign crank_round = crank_total_r + ROUND_HALF;
  assign wheel_round = wheel_total_r + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= status_r;
      if (status_r == ST_COMPLETE) begin
        out_steering          <= bytes_r[1];
        out_heart_rate        <= bytes_r[14];
        out_brake_right       <= bytes_r[4];
        out_brake_left        <= bytes_r[5];
        out_button_flags      <= ~{bytes_r[8], bytes_r[9]};
        out_crank_rpm         <= crank_rpm_r;
        out_flywheel_rpm      <= fly_rpm_r;
        out_crank_revolutions <= crank_round[FRACTION_BITS +: 16];
        out_wheel_revolutions <= wheel_round[FRACTION_BITS +: 32];
        out_event_time        <= ts_r;
      end else begin
        out_steering          <= '0;
        out_heart_rate        <= '0;
        out_brake_right       <= '0;
        out_brake_left        <= '0;
        out_button_flags      <= '0;
        out_crank_rpm         <= '0;
        out_flywheel_rpm      <= '0;
        out_crank_revolutions <= '0;
        out_wheel_revolutions <= '0;
        out_event_time        <= '0;
      end
    end
  end

  `ASSERT_ALWAYS(a_count_range, count_r < BYTE_CNT_W'(PACKET_BYTES),
                 "byte count left at a full packet")

endmodule

// ----- rtl/hex_bike_packet_decoder.sv -----
// An ordinary character is captured, decoded into the packet state and loaded into the
// registered output; the load waits while an untaken result holds the output register. A
// character that completes a good packet first runs four divisions of (38 + FRACTION_BITS)
// quotient bits each on the single shared bit-serial divider. A new character is taken only
// in idle, after the last result is loaded, as the per-item controller sequence sets.
// Reset (synchronous, rst_n low) clears the packet state, last time and revolution totals.
module hex_bike_packet_decoder
  import hbpd_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_input_char,
  input  logic [31:0] in_timestamp_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_steering,
  output logic [7:0]  out_heart_rate,
  output logic [7:0]  out_brake_right,
  output logic [7:0]  out_brake_left,
  output logic [15:0] out_button_flags,
  output logic [15:0] out_crank_rpm,
  output logic [15:0] out_flywheel_rpm,
  output logic [15:0] out_crank_revolutions,
  output logic [31:0] out_wheel_revolutions,
  output logic [31:0] out_event_time
);

  hbpd_cmd_t  cmd;
  hbpd_stat_t stat;

  hbpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hbpd_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .in_input_char         (in_input_char),
    .in_timestamp_ms       (in_timestamp_ms),
    .out_status            (out_status),
    .out_steering          (out_steering),
    .out_heart_rate        (out_heart_rate),
    .out_brake_right       (out_brake_right),
    .out_brake_left        (out_brake_left),
    .out_button_flags      (out_button_flags),
    .out_crank_rpm         (out_crank_rpm),
    .out_flywheel_rpm      (out_flywheel_rpm),
    .out_crank_revolutions (out_crank_revolutions),
    .out_wheel_revolutions (out_wheel_revolutions),
    .out_event_time        (out_event_time)
  );

endmodule
